// ===== rtl/pmrc_pkg.sv =====
// Package for the power monitor reading converter.
// Holds the register-select codes, config indexes, range codes, constants and
// the stage records shared by the pipeline modules. No dependencies.
package pmrc_pkg;

    typedef enum logic [1:0] {
        SEL_BUS     = 2'd0,
        SEL_CURRENT = 2'd1,
        SEL_POWER   = 2'd2,
        SEL_OTHER   = 2'd3
    } sel_t;

    typedef enum logic {
        CFG_BUS_RANGE   = 1'b0,
        CFG_COUNT_SCALE = 1'b1
    } cfg_index_t;

    // bus range codes
    localparam logic [1:0] RANGE_12BIT = 2'b00;
    localparam logic [1:0] RANGE_13BIT = 2'b01;
    localparam logic [1:0] RANGE_60V_A = 2'b10;
    localparam logic [1:0] RANGE_60V_B = 2'b11;

    localparam int FRAC_BITS  = 24;
    localparam int PROD_W     = 48;   // 16 x 32 product
    localparam int MAG_W      = 54;   // product scaled by up to 40
    localparam int WHOLE_W    = MAG_W - FRAC_BITS;
    localparam int THOU_W     = 10;
    localparam int MV_W       = 16;
    localparam int QUOT_W     = 7;    // 65532 / 1000 fits in 7 bits

    localparam logic [9:0]  THOUSAND     = 10'd1000;
    // floor(mv / 1000) == (mv * MV_RECIP) >> RECIP_SHIFT for every 16-bit mv
    localparam logic [16:0] MV_RECIP     = 17'd67109;
    localparam int          RECIP_SHIFT  = 26;

    typedef struct packed {
        sel_t                sel;
        logic                neg;
        logic                wide;
        logic [PROD_W-1:0]   prod;
        logic [MV_W-1:0]     mv;
    } s1_t;

    typedef struct packed {
        sel_t                sel;
        logic                neg;
        logic [MAG_W-1:0]    mag;
        logic [QUOT_W-1:0]   quot;
        logic [MV_W-1:0]     mv;
    } s2_t;

    typedef struct packed {
        sel_t                sel;
        logic                neg;
        logic [WHOLE_W-1:0]  whole;
        logic [THOU_W-1:0]   thou;
    } s3_t;

endpackage

// ===== rtl/pmrc_front.sv =====
// First stage: decodes the register word and forms the raw product.
// Bus words give millivolts; current and power counts are multiplied by the LSB.
// Depends on pmrc_pkg.
module pmrc_front
(
    input  logic             clk,
    input  logic             en,
    input  pmrc_pkg::sel_t   sel,
    input  logic [15:0]      word,
    input  logic [1:0]       bus_range,
    input  logic [31:0]      count_scale,
    output pmrc_pkg::s1_t    s1
);

    pmrc_pkg::s1_t s1_reg;
    pmrc_pkg::s1_t s1_next;

    logic        wide;
    logic        neg;
    logic [15:0] count;
    logic [13:0] field;

    always_comb
    begin
        wide = (bus_range == pmrc_pkg::RANGE_60V_A) || (bus_range == pmrc_pkg::RANGE_60V_B);
        unique case (bus_range)
            pmrc_pkg::RANGE_12BIT: field = {2'b00, word[14:3]};
            pmrc_pkg::RANGE_13BIT: field = {1'b0, word[15:3]};
            pmrc_pkg::RANGE_60V_A,
            pmrc_pkg::RANGE_60V_B: field = word[15:2];
            default:               field = word[15:2];
        endcase

        // current words are two's complement; power words are unsigned
        neg   = (sel == pmrc_pkg::SEL_CURRENT) && word[15];
        count = neg ? (~word + 16'd1) : word;

        s1_next.sel  = sel;
        s1_next.neg  = neg;
        s1_next.wide = wide;
        s1_next.prod = {32'd0, count} * {16'd0, count_scale};
        s1_next.mv   = {field, 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

// ===== rtl/pmrc_scale.sv =====
// Second stage: applies the power scale (x20, x40 in 60 V ranges) and
// estimates the bus-voltage quotient by 1000 via a reciprocal multiply.
// Depends on pmrc_pkg.
module pmrc_scale
(
    input  logic             clk,
    input  logic             en,
    input  pmrc_pkg::s1_t    s1,
    output pmrc_pkg::s2_t    s2
);

    pmrc_pkg::s2_t s2_reg;
    pmrc_pkg::s2_t s2_next;

    logic [pmrc_pkg::MAG_W-1:0] p;
    logic [pmrc_pkg::MAG_W-1:0] p20;
    logic [32:0]                recip_prod;

    always_comb
    begin
        p   = {{(pmrc_pkg::MAG_W - pmrc_pkg::PROD_W){1'b0}}, s1.prod};
        p20 = (p << 4) + (p << 2);
        recip_prod = {17'd0, s1.mv} * {16'd0, pmrc_pkg::MV_RECIP};

        s2_next.sel  = s1.sel;
        s2_next.neg  = s1.neg;
        if (s1.sel == pmrc_pkg::SEL_POWER)
        begin
            s2_next.mag = s1.wide ? (p20 << 1) : p20;
        end
        else
        begin
            s2_next.mag = p;
        end
        s2_next.quot = recip_prod[pmrc_pkg::RECIP_SHIFT +: pmrc_pkg::QUOT_W];
        s2_next.mv   = s1.mv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

// ===== rtl/pmrc_split.sv =====
// Third stage: splits the Q.24 magnitude into whole units and thousandths,
// or forms the bus-voltage remainder. Results are unsigned magnitudes.
// Depends on pmrc_pkg.
module pmrc_split
(
    input  logic             clk,
    input  logic             en,
    input  pmrc_pkg::s2_t    s2,
    output pmrc_pkg::s3_t    s3
);

    pmrc_pkg::s3_t s3_reg;
    pmrc_pkg::s3_t s3_next;

    logic [33:0] frac_prod;
    logic [16:0] quot_k;
    logic [15:0] rem;

    always_comb
    begin
        frac_prod = {10'd0, s2.mag[pmrc_pkg::FRAC_BITS-1:0]} * {24'd0, pmrc_pkg::THOUSAND};
        quot_k    = {10'd0, s2.quot} * {7'd0, pmrc_pkg::THOUSAND};
        rem       = s2.mv - quot_k[15:0];

        s3_next.sel = s2.sel;
        s3_next.neg = s2.neg;
        if (s2.sel == pmrc_pkg::SEL_BUS)
        begin
            s3_next.whole = {{(pmrc_pkg::WHOLE_W - pmrc_pkg::QUOT_W){1'b0}}, s2.quot};
            s3_next.thou  = rem[pmrc_pkg::THOU_W-1:0];
        end
        else
        begin
            s3_next.whole = s2.mag[pmrc_pkg::MAG_W-1:pmrc_pkg::FRAC_BITS];
            s3_next.thou  = frac_prod[pmrc_pkg::FRAC_BITS +: pmrc_pkg::THOU_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
        end
    end

    assign s3 = s3_reg;

endmodule

// ===== rtl/power_monitor_reading_convert.sv =====
// Channel   Dir  Payload (low bit up)                              Handshake
// s_*       in   tuser: reg_select[1:0]; tdata: raw_word[15:0]     s_tvalid/s_tready
// m_*       out  tuser: status; tdata: value_integer[31:0],        m_tvalid/m_tready
//                value_fraction[42:32], zero pad [47:43]
// cfg_*     in   cfg_index selects register, cfg_wdata[31:0]       cfg_we
//
// Four register stages: decode and 16x32 multiply, scale, split, sign and output.
// One item per cycle while m_tready does not stall the output; an accepted item
// passes through the decode, scale, split and output registers in turn before m_tvalid rises.
// Each stage loads whenever it is empty or the next one moves, so a stall
// fills bubbles first and loses nothing. Reset clears the valids and config.
// Top level of the reading converter; uses pmrc_pkg, pmrc_front, pmrc_scale
// and pmrc_split.
module power_monitor_reading_convert
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // raw_word[15:0]
    input  logic [1:0]  s_tuser,   // reg_select[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // value_integer[31:0], value_fraction[42:32], pad
    output logic        m_tuser,   // status

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic [1:0]  bus_range_reg;
    logic [31:0] count_scale_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    pmrc_pkg::s1_t s1;
    pmrc_pkg::s2_t s2;
    pmrc_pkg::s3_t s3;

    logic        status_reg;
    logic [31:0] int_reg;
    logic [10:0] frac_reg;
    logic        status_next;
    logic [31:0] int_next;
    logic [10:0] frac_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_range_reg   <= 2'd0;
            count_scale_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (pmrc_pkg::cfg_index_t'(cfg_index))
                pmrc_pkg::CFG_BUS_RANGE:   bus_range_reg   <= cfg_wdata[1:0];
                pmrc_pkg::CFG_COUNT_SCALE: count_scale_reg <= cfg_wdata;
                default:                   count_scale_reg <= cfg_wdata;
            endcase
        end
    end

    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    pmrc_front u_front
    (
        .clk         (clk),
        .en          (en1),
        .sel         (pmrc_pkg::sel_t'(s_tuser)),
        .word        (s_tdata),
        .bus_range   (bus_range_reg),
        .count_scale (count_scale_reg),
        .s1          (s1)
    );

    pmrc_scale u_scale
    (
        .clk (clk),
        .en  (en2),
        .s1  (s1),
        .s2  (s2)
    );

    pmrc_split u_split
    (
        .clk (clk),
        .en  (en3),
        .s2  (s2),
        .s3  (s3)
    );

    // sign and output stage; a zero magnitude negates to zero, so no check
    always_comb
    begin
        logic [31:0] whole_ext;
        logic [10:0] thou_ext;
        whole_ext = {{(32 - pmrc_pkg::WHOLE_W){1'b0}}, s3.whole};
        thou_ext  = {1'b0, s3.thou};
        if (s3.sel == pmrc_pkg::SEL_OTHER)
        begin
            status_next = 1'b1;
            int_next    = 32'd0;
            frac_next   = 11'd0;
        end
        else
        begin
            status_next = 1'b0;
            int_next    = s3.neg ? (32'd0 - whole_ext) : whole_ext;
            frac_next   = s3.neg ? (11'd0 - thou_ext) : thou_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            status_reg <= status_next;
            int_reg    <= int_next;
            frac_reg   <= frac_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {5'd0, frac_reg, int_reg};

endmodule

// ===== rtl/pmrc_checker.sv =====
// Port-level checks for the reading converter, bound to the top level.
// Depends on power_monitor_reading_convert's port list only.
module pmrc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    logic signed [31:0] val_int;
    logic signed [10:0] val_frac;

    assign val_int  = $signed(m_tdata[31:0]);
    assign val_frac = $signed(m_tdata[42:32]);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // unsupported register gives an all-zero value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 48'd0)
        else $error("failure status with nonzero value");

    // thousandths stay in range and pad bits stay clear
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (val_frac <= 11'sd999) && (val_frac >= -11'sd999)
                     && (m_tdata[47:43] == 5'd0))
        else $error("fraction out of range");

    // fraction never disagrees with the integer's sign
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (val_int != 32'sd0) |-> (val_frac == 11'sd0)
            || ((val_int < 32'sd0) == (val_frac < 11'sd0)))
        else $error("integer and fraction signs differ");

endmodule

bind power_monitor_reading_convert pmrc_checker u_pmrc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/power_monitor_reading_convert_check.sv =====
`timescale 1ns / 100ps
// Checker for the power monitor reading converter: watches the config port and
// both stream channels, predicts each reading and compares it field by field.
// Depends on pmrc_pkg for the select codes, config indexes, range codes and FRAC_BITS.
module power_monitor_reading_convert_check
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // raw_word[15:0]
    input  logic [1:0]  s_tuser,   // reg_select[1:0]

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // value_integer[31:0], value_fraction[42:32], pad
    input  logic        m_tuser,   // status

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,

    output int          fail_count,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic        status;
        logic [31:0] whole;
        logic [10:0] thou;
    } reading_t;

    reading_t    predicted_readings[$];
    logic [1:0]  bus_range;
    logic [31:0] count_scale;

    // Q.24 magnitude to whole units and thousandths, both truncated, then signed
    function automatic reading_t split_q24(logic [63:0] mag, logic neg);
        reading_t    r;
        logic [63:0] whole;
        logic [63:0] thou;
        whole = mag >> pmrc_pkg::FRAC_BITS;
        thou  = ((mag & 64'hFF_FFFF) * 64'd1000) >> pmrc_pkg::FRAC_BITS;
        if (neg)
        begin
            whole = -whole;
            thou  = -thou;
        end
        r.status = 1'b0;
        r.whole  = whole[31:0];
        r.thou   = thou[10:0];
        return r;
    endfunction

    function automatic reading_t convert_reading(pmrc_pkg::sel_t sel, logic [15:0] word,
                                                 logic [1:0] range, logic [31:0] lsb);
        reading_t    r;
        logic        wide;
        logic [31:0] field;
        logic [31:0] mv;
        logic [16:0] count;
        logic [63:0] mag;
        wide = (range == pmrc_pkg::RANGE_60V_A) || (range == pmrc_pkg::RANGE_60V_B);
        r = '0;
        case (sel)
            pmrc_pkg::SEL_BUS:
            begin
                if (wide)
                    field = {18'd0, word[15:2]};
                else if (range == pmrc_pkg::RANGE_13BIT)
                    field = {19'd0, word[15:3]};
                else
                    field = {20'd0, word[14:3]};
                mv = field * 32'd4;
                r.whole = mv / 32'd1000;
                r.thou  = 11'(mv % 32'd1000);
            end
            pmrc_pkg::SEL_CURRENT:
            begin
                // two's complement magnitude; a zero product stays unsigned
                count = word[15] ? (17'h10000 - {1'b0, word}) : {1'b0, word};
                mag = {47'd0, count} * {32'd0, lsb};
                r = split_q24(mag, word[15] && (mag != 64'd0));
            end
            pmrc_pkg::SEL_POWER:
            begin
                mag = {48'd0, word} * {32'd0, lsb} * 64'd20;
                if (wide)
                    mag = mag * 64'd2;
                r = split_q24(mag, 1'b0);
            end
            default:
                r.status = 1'b1;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        fail_count++;
    endtask

    assign pending = predicted_readings.size();

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            bus_range   = pmrc_pkg::RANGE_12BIT;
            count_scale = 32'd0;
            predicted_readings.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                predicted_readings.push_back(convert_reading(pmrc_pkg::sel_t'(s_tuser),
                                                             s_tdata, bus_range,
                                                             count_scale));
            if (m_tvalid && m_tready)
            begin
                checked++;
                if (predicted_readings.size() == 0)
                    report_mismatch("unexpected item", {16'd0, m_tdata}, 64'd0);
                else
                begin
                    want = predicted_readings.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 64'(m_tuser), 64'(want.status));
                    if (m_tdata[31:0] !== want.whole)
                        report_mismatch("value_integer", 64'(m_tdata[31:0]),
                                        64'(want.whole));
                    if (m_tdata[42:32] !== want.thou)
                        report_mismatch("value_fraction", 64'(m_tdata[42:32]),
                                        64'(want.thou));
                    if (m_tdata[47:43] !== 5'd0)
                        report_mismatch("tdata pad", 64'(m_tdata[47:43]), 64'd0);
                end
            end
            // config changes only while idle, so updating after the push is safe
            if (cfg_we)
            begin
                if (cfg_index == pmrc_pkg::CFG_BUS_RANGE)
                    bus_range = cfg_wdata[1:0];
                else
                    count_scale = cfg_wdata;
            end
        end
    end

    initial
    begin
        fail_count = 0;
        checked    = 0;
    end

endmodule

// ===== test/power_monitor_reading_convert_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the power monitor reading converter: clock, reset, stimulus,
// receiver stalls and verdict. Uses pmrc_pkg, the block and the checker module.
module power_monitor_reading_convert_test;

    localparam int PHASES     = 9;
    localparam int PHASE_ITEMS = 200;
    localparam int CYCLE_LIMIT = 500000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;
    logic [1:0]  s_tuser   = pmrc_pkg::SEL_BUS;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = pmrc_pkg::CFG_BUS_RANGE;
    logic [31:0] cfg_wdata = 32'd0;

    int fail_count;
    int pending;
    int checked;
    int cycles       = 0;
    int items_sent   = 0;
    int settings     = 0;
    int burst_left   = 1;
    int stall_mode   = 0;
    int stall_cycle  = 0;

    power_monitor_reading_convert DUT
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    power_monitor_reading_convert_check checker_inst
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d readings still due", cycles, pending);
            $display("power_monitor_reading_convert verification failed");
            $finish;
        end
    end

    // receiver: stall_mode is redrawn at random among free flow, random, sparse and long stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            stall_cycle <= stall_cycle + 1;
            if (stall_cycle % 50 == 49)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= (stall_cycle % 4 == 0);
                default: m_tready <= (stall_cycle % 32 >= 20);
            endcase
        end
    end

    task automatic send_item(pmrc_pkg::sel_t sel, logic [15:0] word);
        s_tvalid <= 1'b1;
        s_tuser  <= sel;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic idle(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        idle(1);
        while (pending != 0)
            @(posedge clk);
    endtask

    // both registers written back to back, only once every reading is out
    task automatic configure(logic [1:0] range, logic [31:0] lsb);
        logic [31:0] junk;
        junk = $urandom;
        drain();
        repeat (6) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= pmrc_pkg::CFG_BUS_RANGE;
        cfg_wdata <= {junk[31:2], range};
        @(posedge clk);
        cfg_index <= pmrc_pkg::CFG_COUNT_SCALE;
        cfg_wdata <= lsb;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [15:0] random_word();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 9))
            0:       w = 16'h0000;
            1:       w = 16'hFFFF;
            2:       w = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            3:       w = $urandom_range(0, 1) ? 16'($urandom_range(0, 15))
                                              : 16'(-$urandom_range(1, 16));
            default: ;
        endcase
        return w;
    endfunction

    function automatic pmrc_pkg::sel_t random_sel();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return pmrc_pkg::SEL_BUS;
        else if (r < 6)
            return pmrc_pkg::SEL_CURRENT;
        else if (r < 9)
            return pmrc_pkg::SEL_POWER;
        return pmrc_pkg::SEL_OTHER;
    endfunction

    function automatic logic [31:0] random_lsb();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(1, 32'h000F_FFFF));
            3:       return 32'h8000_0000 | 32'($urandom);
            default: return 32'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [1:0]  range;
        logic [31:0] lsb;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 1.0 A per count, 12-bit bus field
        configure(pmrc_pkg::RANGE_12BIT, 32'h0100_0000);
        send_item(pmrc_pkg::SEL_BUS, 16'h0000);
        send_item(pmrc_pkg::SEL_BUS, 16'hFFFF);       // bit 15 must be dropped
        send_item(pmrc_pkg::SEL_BUS, 16'h7FF8);
        send_item(pmrc_pkg::SEL_CURRENT, 16'h0000);
        send_item(pmrc_pkg::SEL_CURRENT, 16'h7FFF);
        send_item(pmrc_pkg::SEL_CURRENT, 16'h8000);   // most negative count
        send_item(pmrc_pkg::SEL_CURRENT, 16'hFFFF);
        send_item(pmrc_pkg::SEL_POWER, 16'h0000);
        send_item(pmrc_pkg::SEL_POWER, 16'hFFFF);
        send_item(pmrc_pkg::SEL_OTHER, 16'h1234);
        send_item(pmrc_pkg::SEL_OTHER, 16'hFFFF);

        // largest LSB in a 60 V range: widest products, power doubled
        configure(pmrc_pkg::RANGE_60V_B, 32'hFFFF_FFFF);
        send_item(pmrc_pkg::SEL_BUS, 16'hFFFF);
        send_item(pmrc_pkg::SEL_CURRENT, 16'h8000);
        send_item(pmrc_pkg::SEL_CURRENT, 16'h7FFF);
        send_item(pmrc_pkg::SEL_CURRENT, 16'hFFFF);
        send_item(pmrc_pkg::SEL_POWER, 16'hFFFF);
        send_item(pmrc_pkg::SEL_POWER, 16'h0001);

        // tiny LSB: negative current whose thousandths and whole both truncate to zero
        configure(pmrc_pkg::RANGE_13BIT, 32'h0000_0001);
        send_item(pmrc_pkg::SEL_BUS, 16'hFFFF);
        send_item(pmrc_pkg::SEL_CURRENT, 16'hFFFF);
        send_item(pmrc_pkg::SEL_CURRENT, 16'h8000);
        configure(pmrc_pkg::RANGE_60V_A, 32'h0000_0000);
        send_item(pmrc_pkg::SEL_POWER, 16'hFFFF);
        send_item(pmrc_pkg::SEL_CURRENT, 16'h8000);
        send_item(pmrc_pkg::SEL_BUS, 16'h0003);

        for (int p = 0; p < PHASES; p++)
        begin
            range = 2'(p % 4);
            case (p)
                0:       lsb = 32'h0000_0000;
                1:       lsb = 32'hFFFF_FFFF;
                2:       lsb = 32'h0100_0000;
                default: lsb = random_lsb();
            endcase
            configure(range, lsb);
            burst_left = $urandom_range(1, 24);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                    drain();
                send_item(random_sel(), random_word());
                burst_left--;
                if (burst_left == 0)
                begin
                    idle($urandom_range(1, 8));
                    burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
                end
            end
        end

        drain();
        repeat (20) @(posedge clk);
        $display("sent %0d readings over %0d register settings, all sources and bus ranges",
                 items_sent, settings);
        $display("compared %0d results with %0d mismatches", checked, fail_count);
        if (fail_count == 0)
            $display("power_monitor_reading_convert verification clean");
        else
            $display("power_monitor_reading_convert verification failed");
        $finish;
    end

endmodule
